// ----- rtl/device_address_filter_table_defines.svh -----
// Assertion macros shared by the filter table RTL.
`ifndef DEVICE_ADDRESS_FILTER_TABLE_DEFINES_SVH
`define DEVICE_ADDRESS_FILTER_TABLE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DAFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define DAFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/daft_pkg.sv -----
package daft_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int OP_W          = 2;
    localparam int TYPE_W        = 8;
    localparam int ADDR_W        = 48;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int CAPACITY_W    = 5;
    localparam int DATA_W        = 32;
    localparam int PADDR_W       = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [TYPE_W-1:0] ANON_TYPE = 8'hFF;

    localparam int REG_CAPACITY = 0;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TYPE_W-1:0] address_type;
        logic [ADDR_W-1:0] address;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic                     forward_command;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_t;

    // Command walking the cell row, with what the cells upstream have seen.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TYPE_W-1:0] atype;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              free;
    } tok_t;

    // Table update broadcast to every cell when a command leaves the row.
    typedef struct packed {
        logic              wr;
        logic              inv;
        logic              clr;
        logic [TYPE_W-1:0] atype;
        logic [ADDR_W-1:0] addr;
    } commit_t;

endpackage

// ----- rtl/daft_cell.sv -----
module daft_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  daft_pkg::tok_t    up_tok,
    output logic              dn_valid,
    output daft_pkg::tok_t    dn_tok,
    input  daft_pkg::commit_t commit
);

    logic                          valid_reg;
    logic [daft_pkg::TYPE_W-1:0]   type_reg;
    logic [daft_pkg::ADDR_W-1:0]   addr_reg;
    logic                          mark_hit_reg;
    logic                          mark_free_reg;
    logic                          dn_valid_reg;
    daft_pkg::tok_t                dn_tok_reg;
    daft_pkg::tok_t                dn_tok_next;
    logic                          any_addr;
    logic                          match;

    // Anonymous type matches on type alone, except for lookup.
    assign any_addr = (up_tok.atype == daft_pkg::ANON_TYPE) &&
                      (up_tok.op != daft_pkg::OP_LOOKUP);
    assign match    = valid_reg && (type_reg == up_tok.atype) &&
                      (any_addr || (addr_reg == up_tok.addr));

    always_comb
    begin
        dn_tok_next      = up_tok;
        dn_tok_next.hit  = up_tok.hit | match;
        dn_tok_next.free = up_tok.free | !valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            mark_hit_reg  <= 1'b0;
            mark_free_reg <= 1'b0;
            dn_valid_reg  <= 1'b0;
        end
        else
        begin
            dn_valid_reg <= up_valid;
            if (up_valid)
            begin
                // Only the first matching and first free cells claim the command.
                mark_hit_reg  <= match && !up_tok.hit;
                mark_free_reg <= !valid_reg && !up_tok.free;
            end
            priority if (commit.clr)
                valid_reg <= 1'b0;
            else if (commit.wr && mark_free_reg)
                valid_reg <= 1'b1;
            else if (commit.inv && mark_hit_reg)
                valid_reg <= 1'b0;
            else
                valid_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dn_tok_reg <= dn_tok_next;
        if (commit.wr && mark_free_reg && !commit.clr)
        begin
            type_reg <= commit.atype;
            addr_reg <= commit.addr;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_tok   = dn_tok_reg;

endmodule

// ----- rtl/device_address_filter_table.sv -----
// Device address filter table: up to ENTRIES (address type, address) entries.
// Command channel (cmd_valid/cmd_stall, cmd): add, remove, clear all, lookup.
// A transfer happens on a clock edge with valid high and stall low.
// Response channel (rsp_valid/rsp_stall, rsp): one response per command with
// status, found, forward_command and the entry count after the command.
// Each command walks a row of ENTRIES cells, one cell per cycle, each cell
// holding one entry; the table is updated when it leaves the last cell.
// The response is registered when the command leaves the last cell, and a
// new command is taken only after the previous one has left the row.
// While a response waits on rsp_stall, one further command is accepted and
// its response is parked behind it; cmd_stall stays high until it moves up.
// Reset empties the table, zeroes the count and sets capacity to 0, so adds
// report table full until capacity (APB, byte address 0) is written. The user
// must write capacity only while no command is in flight (not enforced).
`include "device_address_filter_table_defines.svh"

module device_address_filter_table #(
    parameter int ENTRIES = daft_pkg::ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  daft_pkg::cmd_t                 cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output daft_pkg::rsp_t                 rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [daft_pkg::PADDR_W-1:0]   paddr,
    input  logic [daft_pkg::DATA_W-1:0]    pwdata,
    output logic [daft_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int CW        = $clog2(ENTRIES + 1);
    localparam int CMP_W     = (CW > daft_pkg::CAPACITY_W) ? CW : daft_pkg::CAPACITY_W;
    localparam int CNT_OUT_W = daft_pkg::ENTRY_COUNT_W;
    localparam int DW        = daft_pkg::DATA_W;

    logic                              tok_valid [ENTRIES+1];
    daft_pkg::tok_t                    tok       [ENTRIES+1];
    daft_pkg::commit_t                 commit;
    daft_pkg::rsp_t                    result;
    daft_pkg::rsp_t                    rsp_reg;
    daft_pkg::rsp_t                    hold_reg;
    logic                              rsp_valid_reg;
    logic                              hold_valid_reg;
    logic                              busy_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [daft_pkg::CAPACITY_W-1:0]   capacity_reg;
    logic                              accept;
    logic                              exit_valid;
    daft_pkg::tok_t                    exit_tok;
    logic                              full;
    logic                              cap_sel;
    logic                              cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cap_sel   = (paddr[2:2] == 1'(daft_pkg::REG_CAPACITY));
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cap_sel ? DW'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= '0;
        else if (cfg_write && cap_sel)
            capacity_reg <= pwdata[daft_pkg::CAPACITY_W-1:0];
    end

    // ---------------- cell row ----------------
    assign cmd_stall = busy_reg || hold_valid_reg;
    assign accept    = cmd_valid && !cmd_stall;

    assign tok_valid[0]    = accept;
    assign tok[0].op       = cmd.operation;
    assign tok[0].atype    = cmd.address_type;
    assign tok[0].addr     = cmd.address;
    assign tok[0].hit      = 1'b0;
    assign tok[0].free     = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        daft_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (tok_valid[i]),
            .up_tok   (tok[i]),
            .dn_valid (tok_valid[i+1]),
            .dn_tok   (tok[i+1]),
            .commit   (commit)
        );
    end

    assign exit_valid = tok_valid[ENTRIES];
    assign exit_tok   = tok[ENTRIES];

    // ---------------- decision at row exit ----------------
    assign full = (CMP_W'(count_reg) >= CMP_W'(capacity_reg)) || !exit_tok.free;

    always_comb
    begin
        commit.wr              = 1'b0;
        commit.inv             = 1'b0;
        commit.clr             = 1'b0;
        commit.atype           = exit_tok.atype;
        commit.addr            = exit_tok.addr;
        result.status          = daft_pkg::ST_OK;
        result.found           = 1'b0;
        result.forward_command = 1'b0;
        if (exit_valid)
        begin
            unique case (exit_tok.op)
                daft_pkg::OP_ADD:
                begin
                    priority if (exit_tok.hit)
                        result.status = daft_pkg::ST_DUP;
                    else if (full)
                        result.status = daft_pkg::ST_FULL;
                    else
                    begin
                        commit.wr              = 1'b1;
                        result.forward_command = 1'b1;
                    end
                end
                daft_pkg::OP_REMOVE:
                begin
                    commit.inv             = exit_tok.hit;
                    result.found           = exit_tok.hit;
                    result.forward_command = exit_tok.hit;
                end
                daft_pkg::OP_CLEAR:
                begin
                    commit.clr             = 1'b1;
                    result.forward_command = 1'b1;
                end
                daft_pkg::OP_LOOKUP:
                    result.found = exit_tok.hit;
                default:
                    result.found = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        priority if (commit.clr)
            count_next = '0;
        else if (commit.wr)
            count_next = count_reg + CW'(1);
        else if (commit.inv)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;
    end

    assign result.entry_count = CNT_OUT_W'(count_next);

    // ---------------- control and response registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            priority if (accept)
                busy_reg <= 1'b1;
            else if (exit_valid)
                busy_reg <= 1'b0;
            else
                busy_reg <= busy_reg;

            priority if (exit_valid)
            begin
                if (rsp_valid_reg && rsp_stall)
                    hold_valid_reg <= 1'b1;
                else
                    rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                // Parked response moves up as the current one transfers.
                if (hold_valid_reg)
                    hold_valid_reg <= 1'b0;
                else
                    rsp_valid_reg <= 1'b0;
            end
            else
                rsp_valid_reg <= rsp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (exit_valid)
        begin
            if (rsp_valid_reg && rsp_stall)
                hold_reg <= result;
            else
                rsp_reg <= result;
        end
        else if (rsp_valid_reg && !rsp_stall && hold_valid_reg)
            rsp_reg <= hold_reg;
        else
            rsp_reg <= rsp_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    `DAFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg, "command transfer did not mark busy")
    `DAFT_ASSERT_SAME(a_hold_behind, clk, rst_n, hold_valid_reg, rsp_valid_reg && !busy_reg, "parked response without a waiting response or with a command in flight")
    `DAFT_ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(ENTRIES), "entry count above table size")
    `DAFT_ASSERT_NEXT(a_add_count, clk, rst_n, exit_valid && commit.wr, count_reg == $past(count_reg) + CW'(1), "successful add did not raise the count")
    `DAFT_ASSERT_SAME(a_exit_busy, clk, rst_n, exit_valid, busy_reg && !hold_valid_reg, "command left the row while idle or with a response parked")

endmodule
